// ===== sv/bpc_pkg.sv =====
// Shared types, constants and helpers for the button press classifier.
package bpc_pkg;

    localparam int TIMER_BITS = 16;
    localparam int THR_BITS   = 16;
    localparam int CMP_BITS   = (TIMER_BITS > THR_BITS) ? TIMER_BITS : THR_BITS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    typedef enum logic [1:0] {
        REG_ACTIVE_HIGH = 2'd0,
        REG_PULSE_TICKS = 2'd1,
        REG_HOLD_TICKS  = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TRIG  = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_START_OK  = 3'd0,
        KIND_START_ERR = 3'd1,
        KIND_STOP_OK   = 3'd2,
        KIND_INACTIVE  = 3'd3,
        KIND_ACTIVE    = 3'd4,
        KIND_PULSE     = 3'd5,
        KIND_HOLD      = 3'd6
    } t_kind;

    typedef enum logic [4:0] {
        MODE_STOPPED    = 5'b00001,
        MODE_INACTIVE   = 5'b00010,
        MODE_PULSE_WAIT = 5'b00100,
        MODE_HOLD_WAIT  = 5'b01000,
        MODE_HELD       = 5'b10000
    } t_mode;

    typedef struct packed {
        logic                active_high;
        logic [THR_BITS-1:0] pulse_ticks;
        logic [THR_BITS-1:0] hold_ticks;
    } t_cfg;

    // n: number of results (0..2), k0 first, k1 second
    typedef struct packed {
        logic [1:0] n;
        t_kind      k0;
        t_kind      k1;
    } t_res;

    // Incremented count against threshold, threshold clipped to counter max.
    function automatic logic timer_expired(input logic [TIMER_BITS-1:0] cnt_inc,
                                           input logic [THR_BITS-1:0]   thr);
        logic [CMP_BITS-1:0] c;
        logic [CMP_BITS-1:0] l;
        logic [CMP_BITS-1:0] m;
        m = CMP_BITS'({TIMER_BITS{1'b1}});
        l = CMP_BITS'(thr);
        c = CMP_BITS'(cnt_inc);
        if (l > m) begin
            l = m;
        end
        return c >= l;
    endfunction

endpackage

// ===== sv/bpc_regs.sv =====
// APB configuration registers: polarity, pulse time and hold time.
module bpc_regs import bpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output t_cfg                 o_cfg
);

    t_cfg     r_cfg;
    logic     wr_en;
    t_reg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_high <= 1'b1;
            r_cfg.pulse_ticks <= THR_BITS'(50);
            r_cfg.hold_ticks  <= THR_BITS'(1000);
        end else if (wr_en) begin
            unique case (idx)
                REG_ACTIVE_HIGH: r_cfg.active_high <= pwdata[0];
                REG_PULSE_TICKS: r_cfg.pulse_ticks <= pwdata[THR_BITS-1:0];
                REG_HOLD_TICKS:  r_cfg.hold_ticks  <= pwdata[THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ACTIVE_HIGH: prdata = DATA_BITS'(r_cfg.active_high);
            REG_PULSE_TICKS: prdata = DATA_BITS'(r_cfg.pulse_ticks);
            REG_HOLD_TICKS:  prdata = DATA_BITS'(r_cfg.hold_ticks);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/bpc_fsm.sv =====
// Press state machine with tick timer; decides the results of each request.
module bpc_fsm import bpc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_fire,
    input  t_op  i_op,
    input  logic i_pin_level,
    input  logic i_suppress_repeat,
    output t_res o_res
);

    t_mode                 r_mode, n_mode;
    logic [TIMER_BITS-1:0] r_cnt, n_cnt;
    logic                  r_sup, n_sup;
    logic [TIMER_BITS-1:0] cnt_inc;
    logic                  act;
    t_res                  res;

    assign act     = (i_pin_level == i_cfg.active_high);
    assign cnt_inc = (r_cnt == {TIMER_BITS{1'b1}}) ? r_cnt : r_cnt + 1'b1;

    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_sup  = r_sup;
        res.n  = 2'd0;
        res.k0 = KIND_START_OK;
        res.k1 = KIND_START_OK;
        case (i_op)
            OP_START: begin
                if (r_mode == MODE_STOPPED) begin
                    n_sup  = i_suppress_repeat;
                    n_cnt  = '0;
                    res.n  = 2'd2;
                    res.k0 = KIND_START_OK;
                    if (act) begin
                        res.k1 = KIND_ACTIVE;
                        n_mode = MODE_PULSE_WAIT;
                    end else begin
                        res.k1 = KIND_INACTIVE;
                        n_mode = MODE_INACTIVE;
                    end
                end else begin
                    res.n  = 2'd1;
                    res.k0 = KIND_START_ERR;
                end
            end
            OP_STOP: begin
                res.n  = 2'd1;
                res.k0 = KIND_STOP_OK;
                n_mode = MODE_STOPPED;
                n_cnt  = '0;
            end
            OP_TRIG: begin
                unique case (r_mode) inside
                    MODE_STOPPED: ;
                    MODE_INACTIVE: begin
                        if (act) begin
                            res.n  = 2'd1;
                            res.k0 = KIND_ACTIVE;
                            n_mode = MODE_PULSE_WAIT;
                            n_cnt  = '0;
                        end else if (!r_sup) begin
                            res.n  = 2'd1;
                            res.k0 = KIND_INACTIVE;
                        end
                    end
                    MODE_PULSE_WAIT, MODE_HOLD_WAIT, MODE_HELD: begin
                        if (!act) begin
                            n_mode = MODE_INACTIVE;
                            n_cnt  = '0;
                            if (r_mode == MODE_HOLD_WAIT) begin
                                res.n  = 2'd2;
                                res.k0 = KIND_PULSE;
                                res.k1 = KIND_INACTIVE;
                            end else begin
                                res.n  = 2'd1;
                                res.k0 = KIND_INACTIVE;
                            end
                        end else if (!r_sup) begin
                            res.n  = 2'd1;
                            res.k0 = KIND_ACTIVE;
                            n_mode = MODE_PULSE_WAIT;
                            n_cnt  = '0;
                        end
                    end
                    default: ;
                endcase
            end
            default: begin
                unique case (r_mode) inside
                    MODE_PULSE_WAIT: begin
                        if (timer_expired(cnt_inc, i_cfg.pulse_ticks)) begin
                            n_mode = MODE_HOLD_WAIT;
                            n_cnt  = '0;
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                    MODE_HOLD_WAIT, MODE_HELD: begin
                        if (timer_expired(cnt_inc, i_cfg.hold_ticks)) begin
                            res.n  = 2'd1;
                            res.k0 = KIND_HOLD;
                            n_mode = MODE_HELD;
                            n_cnt  = '0;
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_STOPPED;
            r_cnt  <= '0;
            r_sup  <= 1'b1;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_sup  <= n_sup;
        end
    end

    assign o_res = res;

endmodule

// ===== sv/bpc_outq.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle while i_ready is high.
module bpc_outq import bpc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_res  i_res,
    output logic  o_room,
    output logic  o_valid,
    input  logic  i_ready,
    output t_kind o_kind,
    output logic  o_last
);

    t_kind                r_kind [QUEUE_DEPTH];
    logic                 r_last [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr, n_wr;
    logic [QPTR_BITS-1:0] r_rd, n_rd;
    logic [QCNT_BITS-1:0] r_cnt, n_cnt;
    logic [1:0]           push_n;
    logic                 pop;
    logic [QPTR_BITS-1:0] wr1;

    assign push_n = i_push ? i_res.n : 2'd0;
    assign pop    = o_valid & i_ready;
    assign wr1    = r_wr + 1'b1;
    assign n_wr   = r_wr + QPTR_BITS'(push_n);
    assign n_rd   = r_rd + QPTR_BITS'(pop);
    assign n_cnt  = r_cnt + QCNT_BITS'(push_n) - QCNT_BITS'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_kind[r_wr] <= i_res.k0;
            r_last[r_wr] <= (push_n == 2'd1);
        end
        if (push_n == 2'd2) begin
            r_kind[wr1] <= i_res.k1;
            r_last[wr1] <= 1'b1;
        end
    end

    assign o_room  = (r_cnt <= QCNT_BITS'(QUEUE_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_kind  = r_kind[r_rd];
    assign o_last  = r_last[r_rd];

endmodule

// ===== sv/button_press_classifier_core.sv =====
// Top level of the button press classifier: stream in, result stream out, APB config.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser=op, tdata=pin_level,suppress_repeat
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata=kind, tlast=last
//  apb       in   psel/penable/pwrite/pready     paddr, pwdata, prdata
//
//  One request per cycle while s_axis_tready is high; state and timer update in the accepting cycle.
//  Results enter a four-entry queue and leave one per cycle while m_axis_tready is
//  high, so a request giving two results hands them out as two separate transfers.
//  Requests are taken while the queue holds two or fewer results.
//  Synchronous active-low reset; state goes to stopped, config to defaults.
module button_press_classifier_core import bpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [0] pin_level, [1] suppress_repeat
    input  logic [1:0]           s_axis_tuser,   // [1:0] op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [2:0] kind
    output logic                 m_axis_tlast,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    t_cfg  cfg;
    t_res  res;
    logic  room;
    logic  fire;
    t_kind kind;

    assign s_axis_tready = room;
    assign fire          = s_axis_tvalid & room;

    bpc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bpc_fsm u_fsm (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_fire            (fire),
        .i_op              (t_op'(s_axis_tuser)),
        .i_pin_level       (s_axis_tdata[0]),
        .i_suppress_repeat (s_axis_tdata[1]),
        .o_res             (res)
    );

    bpc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_res   (res),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (kind),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, kind};

endmodule
